/* rtl/integer_to_ascii_formatter_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the formatter's checker.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_UNIT_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_UNIT_MACROS_SVH

// clocked, disabled during reset
`define IAF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked, also checked during reset
`define IAF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/iafmt_pkg.sv */
// ----------------------------------------------------------------------------
// iafmt_pkg
// Types and constants for the integer to ASCII formatter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iafmt_pkg;

   localparam int ValueWidth = 16;
   localparam int CharWidth  = 7;
   localparam int WeightWidth = 14;

   localparam logic [1:0] KindDec = 2'd0;
   localparam logic [1:0] KindHex = 2'd1;
   localparam logic [1:0] KindBin = 2'd2;

   localparam logic [CharWidth-1:0] ChDigit0   = 7'h30;
   localparam logic [CharWidth-1:0] ChAlphaOfs = 7'h37;
   localparam logic [CharWidth-1:0] ChSpace    = 7'h20;

   localparam logic [2:0] DecLastIdx = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DEC,
      ST_HEX,
      ST_BIN,
      ST_OUT
   } iafmt_state_type;

   function automatic logic [WeightWidth-1:0] dec_weight(input logic [2:0] idx);
      logic [WeightWidth-1:0] w;
      case (idx)
         3'd0:    w = 14'd10000;
         3'd1:    w = 14'd1000;
         3'd2:    w = 14'd100;
         3'd3:    w = 14'd10;
         default: w = 14'd1;
      endcase
      return w;
   endfunction

endpackage

/* rtl/integer_to_ascii_formatter_unit.sv */
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit
// Prints a 16-bit unsigned number as decimal, hex or binary ASCII text,
// one character per output word, flagging the final character.
// ----------------------------------------------------------------------------
//  channel | direction | payload                 | handshake
//  req     | in        | kind[1:0], value[15:0]  | req_valid / req_stall
//  rsp     | out       | ascii_char[6:0], last   | rsp_valid / rsp_stall
//
// One number at a time; req_stall is high from acceptance until the last
// character word has been taken. Decimal digits come from one shared
// subtract/compare unit: weights are skipped as leading zeros, and each digit d
// is counted by d subtractions before its word is output. Hex and binary print
// 2/4 digits or 9/19 chars. Output stalls hold each word until it is taken.
// Kind 3 is dropped in its acceptance cycle. Synchronous reset returns to idle.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_unit
   import iafmt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_kind,
   input  logic [ValueWidth-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CharWidth-1:0]  rsp_ascii_char,
   output logic                  rsp_last
);

   iafmt_state_type state_ff, state_in;
   logic [1:0]            kind_ff, kind_in;
   logic [ValueWidth-1:0] rem_ff, rem_in;
   logic [ValueWidth-1:0] sh_ff, sh_in;
   logic [2:0]            widx_ff, widx_in;
   logic [3:0]            digit_ff, digit_in;
   logic                  started_ff, started_in;
   logic [4:0]            left_ff, left_in;
   logic                  space_ff, space_in;
   logic [CharWidth-1:0]  char_ff, char_in;
   logic                  last_ff, last_in;

   logic [ValueWidth:0]   diff;
   logic                  borrow;
   logic [3:0]            nib;
   logic [CharWidth-1:0]  hex_char;
   logic                  short_val;

   // shared subtract/compare
   assign diff   = {1'b0, rem_ff} - {{(ValueWidth+1-WeightWidth){1'b0}}, dec_weight(widx_ff)};
   assign borrow = diff[ValueWidth];

   assign nib      = sh_ff[ValueWidth-1 -: 4];
   assign hex_char = (nib < 4'd10) ? ({3'b000, nib} + ChDigit0) : ({3'b000, nib} + ChAlphaOfs);
   assign short_val = (req_value[ValueWidth-1:8] == '0);

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = (state_ff == ST_OUT);
   assign rsp_ascii_char = char_ff;
   assign rsp_last       = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      kind_ff    <= kind_in;
      rem_ff     <= rem_in;
      sh_ff      <= sh_in;
      widx_ff    <= widx_in;
      digit_ff   <= digit_in;
      started_ff <= started_in;
      left_ff    <= left_in;
      space_ff   <= space_in;
      char_ff    <= char_in;
      last_ff    <= last_in;
   end

   always_comb begin
      state_in   = state_ff;
      kind_in    = kind_ff;
      rem_in     = rem_ff;
      sh_in      = sh_ff;
      widx_in    = widx_ff;
      digit_in   = digit_ff;
      started_in = started_ff;
      left_in    = left_ff;
      space_in   = space_ff;
      char_in    = char_ff;
      last_in    = last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in    = req_kind;
               rem_in     = req_value;
               sh_in      = short_val ? {req_value[7:0], 8'h00} : req_value;
               widx_in    = '0;
               digit_in   = '0;
               started_in = 1'b0;
               space_in   = 1'b0;
               case (req_kind)
                  KindDec: begin
                     state_in = ST_DEC;
                  end
                  KindHex: begin
                     left_in  = short_val ? 5'd2 : 5'd4;
                     state_in = ST_HEX;
                  end
                  KindBin: begin
                     left_in  = short_val ? 5'd8 : 5'd16;
                     state_in = ST_BIN;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_DEC: begin
            if (!borrow) begin
               rem_in   = diff[ValueWidth-1:0];
               digit_in = digit_ff + 4'd1;
            end else if (digit_ff != '0 || started_ff || widx_ff == DecLastIdx) begin
               started_in = 1'b1;
               char_in    = ChDigit0 + {3'b000, digit_ff};
               last_in    = (widx_ff == DecLastIdx);
               state_in   = ST_OUT;
            end else begin
               widx_in = widx_ff + 3'd1;
            end
         end
         ST_HEX: begin
            char_in  = hex_char;
            last_in  = (left_ff == 5'd1);
            sh_in    = {sh_ff[ValueWidth-5:0], 4'h0};
            left_in  = left_ff - 5'd1;
            state_in = ST_OUT;
         end
         ST_BIN: begin
            if (space_ff) begin
               char_in  = ChSpace;
               last_in  = 1'b0;
               space_in = 1'b0;
            end else begin
               char_in  = {ChDigit0[CharWidth-1:1], sh_ff[ValueWidth-1]};
               last_in  = (left_ff == 5'd1);
               sh_in    = {sh_ff[ValueWidth-2:0], 1'b0};
               left_in  = left_ff - 5'd1;
               // nibble boundary with bits still to come
               space_in = (left_ff[1:0] == 2'b01) && (left_ff != 5'd1);
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               if (last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  case (kind_ff)
                     KindDec: begin
                        widx_in  = widx_ff + 3'd1;
                        digit_in = '0;
                        state_in = ST_DEC;
                     end
                     KindHex: state_in = ST_HEX;
                     KindBin: state_in = ST_BIN;
                     default: state_in = ST_IDLE;
                  endcase
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/iafmt_checker.sv */
// ----------------------------------------------------------------------------
// iafmt_checker
// Port-level checks for the integer to ASCII formatter, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "integer_to_ascii_formatter_unit_macros.svh"

module iafmt_checker
   import iafmt_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic [1:0]            req_kind,
   input logic [ValueWidth-1:0] req_value,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [CharWidth-1:0]  rsp_ascii_char,
   input logic                  rsp_last
);

   `IAF_ASSERT(a_rsp_held, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_ascii_char) && $stable(rsp_last), "stalled output word changed")
   `IAF_ASSERT(a_req_held, clock, reset, req_valid && req_stall |=> req_valid && $stable(req_kind) && $stable(req_value), "stalled input word changed")
   `IAF_ASSERT(a_busy_while_out, clock, reset, rsp_valid |-> req_stall, "input taken while a word is pending")
   `IAF_ASSERT(a_last_ends, clock, reset, rsp_valid && !rsp_stall && rsp_last |=> !rsp_valid && !req_stall, "no return to idle after final word")
   `IAF_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid && !req_stall, "not idle after reset")

endmodule

bind integer_to_ascii_formatter_unit iafmt_checker u_iafmt_checker (.*);
